/* sv/scanline_scroll_engine_assert.svh */
// assertion helpers for the scanline scroll engine, sampled on clk, held off during reset
`ifndef SCANLINE_SCROLL_ENGINE_ASSERT_SVH
`define SCANLINE_SCROLL_ENGINE_ASSERT_SVH

// same-cycle implication
`define SSCE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanline_scroll_engine: check failed");

// next-cycle implication
`define SSCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanline_scroll_engine: check failed");

`endif

/* sv/ssce_pkg.sv */
`default_nettype none
package ssce_pkg;

	localparam int VISIBLE_LINES = 152;
	localparam int MAX_CALLBACKS = 8;

	localparam int LINE_W     = 8;
	localparam int POS_W      = LINE_W + 1;
	localparam int VAL_W      = 8;
	localparam int SPEED_W    = 8;
	localparam int BASE_W     = 16;
	localparam int CMD_W      = 3;
	localparam int KIND_W     = 2;
	localparam int MODE_W     = 2;
	localparam int SLOT_W     = 3;
	localparam int CNT_W      = $clog2(MAX_CALLBACKS + 1);
	localparam int ADDR_W     = (VISIBLE_LINES > 1) ? $clog2(VISIBLE_LINES) : 1;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_DATA_W   = 24;
	localparam int S_USER_W   = CMD_W;
	localparam int M_DATA_W   = 24;
	localparam int M_USER_W   = KIND_W + 1;

	localparam logic [CMD_W-1:0] CMD_LINE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_X     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_Y     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BAND  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADD   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

	localparam logic [KIND_W-1:0] KIND_X   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_Y   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CB  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_REG = 2'd3;

	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TABLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BAND  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_ON  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_ON  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 3'd4;

	typedef struct packed {
		logic              load;
		logic              rd;
		logic              wr_x;
		logic              wr_y;
		logic              mul;
		logic              fill_pend;
		logic              fill_last;
		logic              fill_step;
		logic              set_pend;
		logic              clr_pend;
		logic              cb_pop;
		logic              cb_clear;
		logic              emit;
		logic [KIND_W-1:0] kind;
		logic              last;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              vis;
		logic [MODE_W-1:0] mode;
		logic              x_on;
		logic              y_on;
		logic              mask_any;
		logic              cb_more;
		logic              pend_valid;
		logic              band_last;
		logic              fill_busy;
		logic              out_free;
	} sts_t;

endpackage
`default_nettype wire

/* sv/ssce_ram.sv */
`default_nettype none
module ssce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 152
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/ssce_ctrl.sv */
`default_nettype none
module ssce_ctrl import ssce_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_LREAD = 4'd2;
	localparam logic [3:0] ST_LX    = 4'd3;
	localparam logic [3:0] ST_LY    = 4'd4;
	localparam logic [3:0] ST_LCB   = 4'd5;
	localparam logic [3:0] ST_REG   = 4'd6;
	localparam logic [3:0] ST_BAND1 = 4'd7;
	localparam logic [3:0] ST_FILLP = 4'd8;
	localparam logic [3:0] ST_BAND2 = 4'd9;
	localparam logic [3:0] ST_FILLL = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       emit_x;
	logic       emit_y;

	assign emit_x   = (sts.mode == MODE_BAND) || ((sts.mode == MODE_TABLE) && sts.x_on);
	assign emit_y   = (sts.mode == MODE_TABLE) && sts.y_on;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				ctl.load = s_tvalid;
				if (s_tvalid) begin
					state_nxt = ST_DISP;
				end
			end
			ST_DISP: begin
				state_nxt = ST_IDLE;
				unique case (sts.cmd)
					CMD_LINE: begin
						if (sts.vis) begin
							ctl.rd    = 1'b1;
							state_nxt = ST_LREAD;
						end
					end
					CMD_X: ctl.wr_x = sts.vis;
					CMD_Y: ctl.wr_y = sts.vis;
					CMD_BAND: begin
						ctl.mul   = 1'b1;
						state_nxt = ST_BAND1;
					end
					CMD_ADD: state_nxt = ST_REG;
					CMD_CLEAR: ctl.cb_clear = 1'b1;
					default: ;
				endcase
			end
			ST_LREAD: begin
				priority if (emit_x) begin
					state_nxt = ST_LX;
				end else if (emit_y) begin
					state_nxt = ST_LY;
				end else if (sts.mask_any) begin
					state_nxt = ST_LCB;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_LX: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					ctl.kind = KIND_X;
					ctl.last = !emit_y && !sts.mask_any;
					priority if (emit_y) begin
						state_nxt = ST_LY;
					end else if (sts.mask_any) begin
						state_nxt = ST_LCB;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_LY: begin
				if (sts.out_free) begin
					ctl.emit  = 1'b1;
					ctl.kind  = KIND_Y;
					ctl.last  = !sts.mask_any;
					state_nxt = sts.mask_any ? ST_LCB : ST_IDLE;
				end
			end
			ST_LCB: begin
				if (sts.out_free) begin
					ctl.emit   = 1'b1;
					ctl.kind   = KIND_CB;
					ctl.cb_pop = 1'b1;
					ctl.last   = !sts.cb_more;
					state_nxt  = sts.cb_more ? ST_LCB : ST_IDLE;
				end
			end
			ST_REG: begin
				if (sts.out_free) begin
					ctl.emit  = 1'b1;
					ctl.kind  = KIND_REG;
					ctl.last  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_BAND1: begin
				if (sts.pend_valid) begin
					ctl.fill_pend = 1'b1;
					state_nxt     = ST_FILLP;
				end else begin
					state_nxt = ST_BAND2;
				end
			end
			ST_FILLP: begin
				if (sts.fill_busy) begin
					ctl.fill_step = 1'b1;
				end else begin
					state_nxt = ST_BAND2;
				end
			end
			ST_BAND2: begin
				if (sts.band_last) begin
					ctl.fill_last = 1'b1;
					ctl.clr_pend  = 1'b1;
					state_nxt     = ST_FILLL;
				end else begin
					ctl.set_pend = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			ST_FILLL: begin
				if (sts.fill_busy) begin
					ctl.fill_step = 1'b1;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

/* sv/ssce_dp.sv */
`default_nettype none
module ssce_dp import ssce_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic [S_USER_W-1:0]   s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_DATA_W-1:0]   m_tdata,
	output logic                       m_tlast,
	output logic      [M_USER_W-1:0]   m_tuser,
	input  wire ctl_t                  ctl,
	output sts_t                       sts
);

	localparam int PROD_W = BASE_W + SPEED_W;

	// input item
	logic [CMD_W-1:0]   cmd_q;
	logic [LINE_W-1:0]  line_q;
	logic [VAL_W-1:0]   entry_q;
	logic [SPEED_W-1:0] speed_q;
	logic               last_q;

	// configuration
	logic               plane_q;
	logic [MODE_W-1:0]  mode_q;
	logic               x_on_q;
	logic               y_on_q;
	logic [BASE_W-1:0]  base_q;

	logic [ADDR_W-1:0]  line_addr;
	logic               vis;
	logic [VAL_W-1:0]   x_rd;
	logic [VAL_W-1:0]   y_rd;
	logic [VAL_W-1:0]   band_rd;
	logic [VISIBLE_LINES-1:0] band_vld_q;
	logic               band_vld_s1;

	logic [PROD_W-1:0]  prod;
	logic [VAL_W-1:0]   sx_q;
	logic [LINE_W-1:0]  pend_top_q;
	logic [VAL_W-1:0]   pend_off_q;
	logic               pend_valid_q;

	logic [POS_W-1:0]   fill_cur_q;
	logic [POS_W-1:0]   fill_end_q;
	logic [VAL_W-1:0]   fill_val_q;
	logic [POS_W-1:0]   line_end;

	logic [LINE_W-1:0]        cb_line_q [MAX_CALLBACKS];
	logic [CNT_W-1:0]         cb_cnt_q;
	logic                     cb_full;
	logic [MAX_CALLBACKS-1:0] match;
	logic [MAX_CALLBACKS-1:0] mask_q;
	logic [MAX_CALLBACKS-1:0] mask_rest;
	logic [SLOT_W-1:0]        low_idx;

	logic               out_vld_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic               out_plane_q;
	logic [VAL_W-1:0]   out_value_q;
	logic [LINE_W-1:0]  out_line_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic               out_full_q;
	logic               out_last_q;
	logic [VAL_W-1:0]   emit_value;
	logic [SLOT_W-1:0]  emit_slot;

	assign line_addr = line_q[ADDR_W-1:0];
	assign vis       = ({1'b0, line_q} < POS_W'(VISIBLE_LINES));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= s_tuser;
			line_q  <= s_tdata[0 +: LINE_W];
			entry_q <= s_tdata[LINE_W +: VAL_W];
			speed_q <= s_tdata[LINE_W + VAL_W +: SPEED_W];
			last_q  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= 1'b0;
			mode_q  <= MODE_OFF;
			x_on_q  <= 1'b0;
			y_on_q  <= 1'b0;
			base_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PLANE: plane_q <= cfg_data[0];
				REG_MODE:  mode_q  <= cfg_data[MODE_W-1:0];
				REG_X_ON:  x_on_q  <= cfg_data[0];
				REG_Y_ON:  y_on_q  <= cfg_data[0];
				REG_BASE:  base_q  <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	ssce_ram #(.WIDTH(VAL_W), .DEPTH(VISIBLE_LINES)) u_x_ram (
		.clk   (clk),
		.we    (ctl.wr_x),
		.waddr (line_addr),
		.wdata (entry_q),
		.re    (ctl.rd),
		.raddr (line_addr),
		.rdata (x_rd)
	);

	ssce_ram #(.WIDTH(VAL_W), .DEPTH(VISIBLE_LINES)) u_y_ram (
		.clk   (clk),
		.we    (ctl.wr_y),
		.waddr (line_addr),
		.wdata (entry_q),
		.re    (ctl.rd),
		.raddr (line_addr),
		.rdata (y_rd)
	);

	ssce_ram #(.WIDTH(VAL_W), .DEPTH(VISIBLE_LINES)) u_band_ram (
		.clk   (clk),
		.we    (ctl.fill_step),
		.waddr (fill_cur_q[ADDR_W-1:0]),
		.wdata (fill_val_q),
		.re    (ctl.rd),
		.raddr (line_addr),
		.rdata (band_rd)
	);

	// unwritten band entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_vld_q <= '0;
		end else if (ctl.fill_step) begin
			band_vld_q[fill_cur_q[ADDR_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			band_vld_s1 <= band_vld_q[line_addr];
		end
	end

	assign prod = base_q * speed_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			sx_q <= prod[FRAC_W +: VAL_W];
		end
		if (ctl.set_pend) begin
			pend_top_q <= line_q;
			pend_off_q <= sx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (ctl.set_pend) begin
			pend_valid_q <= 1'b1;
		end else if (ctl.clr_pend) begin
			pend_valid_q <= 1'b0;
		end
	end

	assign line_end = vis ? {1'b0, line_q} : POS_W'(VISIBLE_LINES);

	always_ff @(posedge clk) begin
		priority if (ctl.fill_pend) begin
			fill_cur_q <= {1'b0, pend_top_q};
			fill_end_q <= line_end;
			fill_val_q <= pend_off_q;
		end else if (ctl.fill_last) begin
			fill_cur_q <= {1'b0, line_q};
			fill_end_q <= POS_W'(VISIBLE_LINES);
			fill_val_q <= sx_q;
		end else if (ctl.fill_step) begin
			fill_cur_q <= fill_cur_q + 1'b1;
		end
	end

	// callback slots
	assign cb_full = (cb_cnt_q >= CNT_W'(MAX_CALLBACKS));

	always_comb begin
		for (int i = 0; i < MAX_CALLBACKS; i++) begin
			match[i] = (CNT_W'(i) < cb_cnt_q) && (cb_line_q[i] == line_q);
		end
	end

	always_comb begin
		low_idx = '0;
		for (int i = MAX_CALLBACKS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = SLOT_W'(i);
			end
		end
	end

	assign mask_rest = mask_q & (mask_q - 1'b1);

	always_ff @(posedge clk) begin
		if (ctl.emit && (ctl.kind == KIND_REG) && !cb_full) begin
			cb_line_q[cb_cnt_q[SLOT_W-1:0]] <= line_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_cnt_q <= '0;
			mask_q   <= '0;
		end else begin
			if (ctl.cb_clear) begin
				cb_cnt_q <= '0;
			end else if (ctl.emit && (ctl.kind == KIND_REG) && !cb_full) begin
				cb_cnt_q <= cb_cnt_q + 1'b1;
			end
			if (ctl.rd) begin
				mask_q <= match;
			end else if (ctl.cb_pop) begin
				mask_q <= mask_rest;
			end
		end
	end

	// result register
	always_comb begin
		emit_value = '0;
		emit_slot  = '0;
		unique case (ctl.kind)
			KIND_X: begin
				if (mode_q == MODE_BAND) begin
					emit_value = band_vld_s1 ? band_rd : '0;
				end else begin
					emit_value = x_rd;
				end
			end
			KIND_Y:   emit_value = y_rd;
			KIND_CB:  emit_slot  = low_idx;
			KIND_REG: emit_slot  = cb_full ? '0 : cb_cnt_q[SLOT_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_kind_q  <= ctl.kind;
			out_plane_q <= ((ctl.kind == KIND_X) || (ctl.kind == KIND_Y)) ? plane_q : 1'b0;
			out_value_q <= emit_value;
			out_line_q  <= line_q;
			out_slot_q  <= emit_slot;
			out_full_q  <= (ctl.kind == KIND_REG) && cb_full;
			out_last_q  <= ctl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_full_q, out_kind_q};
	assign m_tdata  = {{(M_DATA_W - 1 - VAL_W - LINE_W - SLOT_W){1'b0}},
		out_slot_q, out_line_q, out_value_q, out_plane_q};

	assign sts.cmd        = cmd_q;
	assign sts.vis        = vis;
	assign sts.mode       = mode_q;
	assign sts.x_on       = x_on_q;
	assign sts.y_on       = y_on_q;
	assign sts.mask_any   = |mask_q;
	assign sts.cb_more    = |mask_rest;
	assign sts.pend_valid = pend_valid_q;
	assign sts.band_last  = last_q;
	assign sts.fill_busy  = (fill_cur_q < fill_end_q);
	assign sts.out_free   = !out_vld_q || m_tready;

endmodule
`default_nettype wire

/* sv/scanline_scroll_engine.sv */
// Scanline scroll engine.
// Input stream s_*: one command per transfer (table write, parallax band, callback
// registration, callback clear, or a line event from horizontal blank).
// Output stream m_*: scroll offset writes, callback events and registration answers;
// m_tlast marks the last result of an input transfer.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; the user must see that it is
// written only while the block idles, which the block itself does not enforce. A visible
// line event emits its results (up to 10) at one result per cycle while the output
// register is free. A band writes one band buffer line per cycle in each fill pass
// (at most 152 lines in all), as the band buffer has a single write port.
// Items are taken one at a time; s_tready is high while the controller idles, even
// when a result still waits in the output register.
// When m_tready is low the engine holds its next result and waits; no result is lost.
// Reset clears the configuration, the band buffer (read as zero), the callback list and
// the pending band; X and Y tables hold no defined contents until written.
`default_nettype none
`include "scanline_scroll_engine_assert.svh"
module scanline_scroll_engine import ssce_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// line_number [7:0], entry_value [15:8], band_speed [23:16]
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	input  wire logic                  s_tlast,
	// cmd [2:0]
	input  wire logic [S_USER_W-1:0]   s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// which_plane [0], offset_value [8:1], event_line [16:9], slot_index [19:17], zero above
	output logic      [M_DATA_W-1:0]   m_tdata,
	output logic                       m_tlast,
	// event_kind [1:0], table_full [2]
	output logic      [M_USER_W-1:0]   m_tuser
);

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ssce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	ssce_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.ctl       (ctl),
		.sts       (sts)
	);

	`SSCE_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
	`SSCE_ASSERT_NOW(a_reg_last, m_tvalid && (m_tuser[KIND_W-1:0] == KIND_REG), m_tlast)
	`SSCE_ASSERT_NOW(a_full_kind, m_tvalid && m_tuser[KIND_W], m_tuser[KIND_W-1:0] == KIND_REG)
	`SSCE_ASSERT_NOW(a_fill_quiet, ctl.fill_step, !ctl.emit && !s_tready)

endmodule
`default_nettype wire
